// ----- hw/rtl/mave_pkg.sv -----
package mave_pkg;

    // Field widths of the channels and registers.
    localparam int FUNC_W = 2;
    localparam int RAW_W  = 16;
    localparam int TS_W   = 32;
    localparam int POS_W  = 48;
    localparam int VEL_W  = 32;
    localparam int CPR_W  = 17;
    localparam int HZ_W   = 32;
    localparam int TURN_W = 32;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_SEL_CPR = 1'b0;
    localparam logic REG_SEL_HZ  = 1'b1;
    localparam logic [CPR_W-1:0] CPR_RESET = 17'd4096;
    localparam logic [HZ_W-1:0]  HZ_RESET  = 32'd168000000;

    // Item selector codes.
    localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ANGLE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_VEL   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Reciprocal constants for an exact floor(x / 1000) on 32-bit x.
    localparam int DIV1000_MUL_W = 29;
    localparam logic [DIV1000_MUL_W-1:0] DIV1000_MUL = 29'd274877907;
    localparam int DIV1000_SHIFT = 38;
    localparam int HZK_W = 23;

    // Velocity saturation limits.
    localparam logic [VEL_W-1:0] VEL_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [VEL_W-1:0] VEL_NEG_SAT = 32'h8000_0000;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  pos;
        logic [TS_W-1:0]   ts;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_flags_t;

endpackage

// ----- hw/rtl/mave_if.sv -----
interface mave_in_if;
    logic                        valid;
    logic                        ready;
    logic [mave_pkg::FUNC_W-1:0] func;
    logic [mave_pkg::RAW_W-1:0]  raw_count;
    logic [mave_pkg::TS_W-1:0]   timestamp;

    modport source (output valid, output func, output raw_count, output timestamp,
                    input ready);
    modport sink   (input valid, input func, input raw_count, input timestamp,
                    output ready);
endinterface

interface mave_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [mave_pkg::POS_W-1:0] position_counts;
    logic signed [mave_pkg::VEL_W-1:0] velocity_cps;
    logic                              velocity_valid;

    modport source (output valid, output position_counts, output velocity_cps,
                    output velocity_valid, input ready);
    modport sink   (input valid, input position_counts, input velocity_cps,
                    input velocity_valid, output ready);
endinterface

// ----- hw/rtl/mave_queue.sv -----
module mave_queue #(
    parameter int DEPTH = mave_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mave_pkg::q_entry_t push_entry,
    input  logic               pop,
    output mave_pkg::q_entry_t head_entry,
    output mave_pkg::q_flags_t flags
);
    import mave_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    q_entry_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_entry  = entry_reg[rd_ptr_reg];
    assign flags.full  = (count_reg == FULL_CNT);
    assign flags.empty = (count_reg == '0);

endmodule

// ----- hw/rtl/mave_front.sv -----
module mave_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [mave_pkg::CPR_W-1:0]   counts_per_rev,
    mave_in_if.sink                      in_ch,
    input  mave_pkg::q_flags_t           flags,
    output logic                         push,
    output mave_pkg::q_entry_t           push_entry
);
    import mave_pkg::*;

    logic                     busy_reg, busy_next;
    logic [FUNC_W-1:0]        func_reg, func_next;
    logic [TS_W-1:0]          ts_reg, ts_next;
    logic [RAW_W-1:0]         prev_raw_reg, prev_raw_next;
    logic [TURN_W-1:0]        turn_reg, turn_next;

    logic                     accept;
    logic signed [RAW_W:0]    diff;
    logic [RAW_W:0]           mag;
    logic [RAW_W+3:0]         mag5;
    logic [RAW_W+3:0]         cpr4;
    logic                     wrap;
    logic signed [TURN_W+CPR_W:0] prod;

    assign in_ch.ready = !busy_reg && !flags.full;
    assign accept      = in_ch.valid && in_ch.ready;

    // Unwrap decision: a jump of more than 4/5 of a turn is taken as a wrap.
    always_comb
    begin
        diff = $signed({1'b0, in_ch.raw_count}) - $signed({1'b0, prev_raw_reg});
        mag  = diff[RAW_W] ? (17'd0 - diff) : diff;
        mag5 = {1'b0, mag, 2'b00} + {3'b000, mag};
        cpr4 = {1'b0, counts_per_rev, 2'b00};
        wrap = (mag5 > cpr4);
    end

    always_comb
    begin
        busy_next     = busy_reg;
        func_next     = func_reg;
        ts_next       = ts_reg;
        prev_raw_next = prev_raw_reg;
        turn_next     = turn_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            func_next = in_ch.func;
            ts_next   = in_ch.timestamp;
            unique case (in_ch.func)
                FUNC_INIT:
                begin
                    prev_raw_next = in_ch.raw_count;
                    turn_next     = '0;
                end
                FUNC_ANGLE, FUNC_VEL:
                begin
                    prev_raw_next = in_ch.raw_count;
                    if (wrap)
                    begin
                        turn_next = diff[RAW_W] ? turn_reg + 1'b1 : turn_reg - 1'b1;
                    end
                end
                default:
                begin
                    prev_raw_next = prev_raw_reg;
                end
            endcase
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            prev_raw_reg <= '0;
            turn_reg     <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            prev_raw_reg <= prev_raw_next;
            turn_reg     <= turn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        ts_reg   <= ts_next;
    end

    // After the state update the position is always turns * cpr + prev_raw.
    always_comb
    begin
        prod = $signed(turn_reg) * $signed({1'b0, counts_per_rev});
        push_entry.func = func_reg;
        push_entry.ts   = ts_reg;
        push_entry.pos  = prod[POS_W-1:0] + {{(POS_W-RAW_W){1'b0}}, prev_raw_reg};
    end

    assign push = busy_reg;

endmodule

// ----- hw/rtl/mave_back.sv -----
module mave_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mave_pkg::HZ_W-1:0]   clock_hz,
    input  mave_pkg::q_entry_t          head_entry,
    input  mave_pkg::q_flags_t          flags,
    output logic                        pop,
    mave_out_if.source                  out_ch
);
    import mave_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DT   = 4'd1;
    localparam logic [3:0] ST_MLO  = 4'd2;
    localparam logic [3:0] ST_MHI  = 4'd3;
    localparam logic [3:0] ST_SUM  = 4'd4;
    localparam logic [3:0] ST_CHK  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_DONE = 4'd7;

    localparam int HALF_W = POS_W / 2;
    localparam int PP_W   = HALF_W + HZ_W;
    localparam int NUM_W  = POS_W + HZ_W;
    localparam int QB_W   = VEL_W - 1;
    localparam int CNT_W  = $clog2(QB_W);
    localparam int HZP_W  = HZ_W + DIV1000_MUL_W;

    logic [3:0]        state_reg, state_next;
    logic [POS_W-1:0]  prev_pos_reg, prev_pos_next;
    logic [TS_W-1:0]   prev_ts_reg, prev_ts_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [TS_W-1:0]   ts_reg, ts_next;
    logic [TS_W-1:0]   dt_reg, dt_next;
    logic              neg_reg, neg_next;
    logic [POS_W-1:0]  mag_reg, mag_next;
    logic [PP_W-1:0]   plo_reg, plo_next;
    logic [PP_W-1:0]   phi_reg, phi_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [TS_W-1:0]   rem_reg, rem_next;
    logic [QB_W-1:0]   work_reg, work_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              sat_reg, sat_next;
    logic [HZK_W-1:0]  hzk_reg, hzk_next;

    logic              ovalid_reg, ovalid_next;
    logic [POS_W-1:0]  opos_reg, opos_next;
    logic [VEL_W-1:0]  ovel_reg, ovel_next;
    logic              ovv_reg, ovv_next;

    logic [HZP_W-1:0]  hz_prod;
    logic [HZK_W-1:0]  hz_q;
    logic [TS_W-1:0]   dt_raw;
    logic              dt_subst;
    logic [POS_W:0]    delta;
    logic [POS_W:0]    delta_abs;
    logic [TS_W:0]     rem_sh;
    logic              qbit;
    logic [VEL_W-1:0]  q32;
    logic [VEL_W-1:0]  vel;
    logic              can_load;

    // Substitute period clock_hz / 1000 by reciprocal multiply, never below one.
    always_comb
    begin
        hz_prod  = HZP_W'(clock_hz) * HZP_W'(DIV1000_MUL);
        hz_q     = hz_prod[HZP_W-1:DIV1000_SHIFT];
        hzk_next = (hz_q == '0) ? HZK_W'(1) : hz_q;
    end

    always_comb
    begin
        dt_raw    = ts_reg - prev_ts_reg;
        dt_subst  = (dt_raw == '0) || ({dt_raw, 1'b0} > {1'b0, clock_hz});
        delta     = {pos_reg[POS_W-1], pos_reg} - {prev_pos_reg[POS_W-1], prev_pos_reg};
        delta_abs = delta[POS_W] ? ((POS_W+1)'(0) - delta) : delta;
        rem_sh    = {rem_reg, work_reg[QB_W-1]};
        qbit      = (rem_sh >= {1'b0, dt_reg});
        q32       = {1'b0, work_reg};
        if (sat_reg)
        begin
            vel = neg_reg ? VEL_NEG_SAT : VEL_POS_SAT;
        end
        else
        begin
            vel = neg_reg ? (VEL_W'(0) - q32) : q32;
        end
    end

    assign can_load = !ovalid_reg || out_ch.ready;

    always_comb
    begin
        state_next    = state_reg;
        prev_pos_next = prev_pos_reg;
        prev_ts_next  = prev_ts_reg;
        pos_next      = pos_reg;
        ts_next       = ts_reg;
        dt_next       = dt_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        plo_next      = plo_reg;
        phi_next      = phi_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        work_next     = work_reg;
        cnt_next      = cnt_reg;
        sat_next      = sat_reg;
        opos_next     = opos_reg;
        ovel_next     = ovel_reg;
        ovv_next      = ovv_reg;
        ovalid_next   = ovalid_reg && !out_ch.ready;
        pop           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!flags.empty)
                begin
                    if (head_entry.func == FUNC_VEL)
                    begin
                        pop        = 1'b1;
                        pos_next   = head_entry.pos;
                        ts_next    = head_entry.ts;
                        state_next = ST_DT;
                    end
                    else if (can_load)
                    begin
                        pop         = 1'b1;
                        ovalid_next = 1'b1;
                        opos_next   = head_entry.pos;
                        ovel_next   = '0;
                        ovv_next    = 1'b0;
                        if (head_entry.func == FUNC_INIT)
                        begin
                            prev_ts_next = head_entry.ts;
                        end
                    end
                end
            end
            ST_DT:
            begin
                dt_next    = dt_subst ? TS_W'(hzk_reg) : dt_raw;
                neg_next   = delta[POS_W];
                mag_next   = delta_abs[POS_W-1:0];
                state_next = ST_MLO;
            end
            ST_MLO:
            begin
                plo_next   = PP_W'(mag_reg[HALF_W-1:0]) * PP_W'(clock_hz);
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                phi_next   = PP_W'(mag_reg[POS_W-1:HALF_W]) * PP_W'(clock_hz);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                num_next   = {phi_reg, {HALF_W{1'b0}}} + NUM_W'(plo_reg);
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                // Quotient at or above 2^31 saturates either way.
                if (num_reg[NUM_W-1:QB_W] >= (NUM_W-QB_W)'(dt_reg))
                begin
                    sat_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    sat_next   = 1'b0;
                    rem_next   = num_reg[QB_W+TS_W-1:QB_W];
                    work_next  = num_reg[QB_W-1:0];
                    cnt_next   = CNT_W'(QB_W - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = qbit ? TS_W'(rem_sh - {1'b0, dt_reg}) : rem_sh[TS_W-1:0];
                work_next = {work_reg[QB_W-2:0], qbit};
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (can_load)
                begin
                    ovalid_next   = 1'b1;
                    opos_next     = pos_reg;
                    ovel_next     = vel;
                    ovv_next      = 1'b1;
                    prev_pos_next = pos_reg;
                    prev_ts_next  = ts_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            prev_pos_reg <= '0;
            prev_ts_reg  <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            prev_pos_reg <= prev_pos_next;
            prev_ts_reg  <= prev_ts_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        ts_reg   <= ts_next;
        dt_reg   <= dt_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        work_reg <= work_next;
        cnt_reg  <= cnt_next;
        sat_reg  <= sat_next;
        hzk_reg  <= hzk_next;
        opos_reg <= opos_next;
        ovel_reg <= ovel_next;
        ovv_reg  <= ovv_next;
    end

    assign out_ch.valid           = ovalid_reg;
    assign out_ch.position_counts = opos_reg;
    assign out_ch.velocity_cps    = ovel_reg;
    assign out_ch.velocity_valid  = ovv_reg;

endmodule

// ----- hw/rtl/multiturn_angle_velocity_estimator_top.sv -----
// Channel   Direction  Payload                                         Transfer when
// in_ch     sink       func, raw_count, timestamp                      valid && ready
// out_ch    source     position_counts, velocity_cps, velocity_valid   valid && ready
// APB       slave      counts_per_rev @ 0x0, clock_hz @ 0x4            psel && penable && pwrite
//
// The front takes an item only while it is idle and the queue has room; it updates the turn
// counter and forms the position with one 32x18 multiply.
// Items without velocity go from the queue head straight to the output register. A velocity
// item passes the split 48x32 multiply and, unless saturated, the 31-step restoring divider.
// Reset (rst_n, asynchronous, active low) clears the unwrap and velocity state and
// loads the register defaults. Either side may stall freely: the queue and the output
// register decouple the input transfer from the result transfer.
module multiturn_angle_velocity_estimator_top #(
    parameter int QUEUE_DEPTH = mave_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    mave_in_if.sink                       in_ch,
    mave_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mave_pkg::APB_AW-1:0]   paddr,
    input  logic [mave_pkg::APB_DW-1:0]   pwdata,
    output logic [mave_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import mave_pkg::*;

    logic [CPR_W-1:0] cpr_reg, cpr_next;
    logic [HZ_W-1:0]  hz_reg, hz_next;
    logic             wr_en;

    q_entry_t push_entry;
    q_entry_t head_entry;
    q_flags_t flags;
    logic     push;
    logic     pop;

    // Register write at the access phase; the word address selects the register.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cpr_next = cpr_reg;
        hz_next  = hz_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_SEL_CPR: cpr_next = pwdata[CPR_W-1:0];
                REG_SEL_HZ:  hz_next  = pwdata;
                default:     cpr_next = cpr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg <= CPR_RESET;
            hz_reg  <= HZ_RESET;
        end
        else
        begin
            cpr_reg <= cpr_next;
            hz_reg  <= hz_next;
        end
    end

    assign prdata = (paddr[2] == REG_SEL_HZ) ? hz_reg
                                             : {{(APB_DW-CPR_W){1'b0}}, cpr_reg};

    // The front unwraps the count and queues the position with its timestamp.
    mave_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .counts_per_rev (cpr_reg),
        .in_ch          (in_ch),
        .flags          (flags),
        .push           (push),
        .push_entry     (push_entry)
    );

    mave_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .flags      (flags)
    );

    // The back estimates velocity and owns the output register.
    mave_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .clock_hz   (hz_reg),
        .head_entry (head_entry),
        .flags      (flags),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule
